// File: hdl/a64frf_pkg.sv
// ----------------------------------------------------------------------------
// a64frf_pkg: shared types and constants of the free register finder
// Instruction match rules, register pick order and the reserved-mask reset.
// ----------------------------------------------------------------------------
package a64frf_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned REG_W  = 5;
  localparam int unsigned NUM_REGS = 32;

  // Register fields that a rule marks
  localparam logic [3:0] USE_RD  = 4'b0001;
  localparam logic [3:0] USE_RN  = 4'b0010;
  localparam logic [3:0] USE_RM  = 4'b0100;
  localparam logic [3:0] USE_RT2 = 4'b1000;

  localparam logic [NUM_REGS-1:0] RESERVED_RESET = 32'h0004_0300;

  // Status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam logic [REG_W-1:0] NO_REG = 5'd0;

  typedef struct packed {
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] pattern;
    logic [3:0]        uses;
  } rule_t;

  localparam int unsigned NUM_RULES = 28;

  localparam rule_t RULES [NUM_RULES] = '{
    '{32'h7FE0_0000, 32'h0B20_0000, USE_RM | USE_RN | USE_RD},   // add ext
    '{32'h7FE0_0000, 32'h2B20_0000, USE_RM | USE_RN | USE_RD},   // adds ext
    '{32'h7F80_0000, 32'h1100_0000, USE_RN | USE_RD},            // add imm
    '{32'h7F80_0000, 32'h3100_0000, USE_RN | USE_RD},            // adds imm
    '{32'h7F20_0000, 32'h0B00_0000, USE_RM | USE_RN | USE_RD},   // add shifted
    '{32'h7F20_0000, 32'h2B00_0000, USE_RM | USE_RN | USE_RD},   // adds shifted
    '{32'h9F00_0000, 32'h1000_0000, USE_RD},                     // adr
    '{32'h9F00_0000, 32'h9000_0000, USE_RD},                     // adrp
    '{32'h7F80_0000, 32'h1200_0000, USE_RN | USE_RD},            // and imm
    '{32'h7F80_0000, 32'h7200_0000, USE_RN | USE_RD},            // ands imm
    '{32'h7F20_0000, 32'h0A00_0000, USE_RM | USE_RN | USE_RD},   // and shifted
    '{32'h7F20_0000, 32'h6A00_0000, USE_RM | USE_RN | USE_RD},   // ands shifted
    '{32'h7FE0_0000, 32'h4B20_0000, USE_RM | USE_RN | USE_RD},   // sub ext
    '{32'h7FE0_0000, 32'h6B20_0000, USE_RM | USE_RN | USE_RD},   // subs ext
    '{32'h7F80_0000, 32'h5100_0000, USE_RN | USE_RD},            // sub imm
    '{32'h7F80_0000, 32'h7100_0000, USE_RN | USE_RD},            // subs imm
    '{32'h7F20_0000, 32'h4B00_0000, USE_RM | USE_RN | USE_RD},   // sub shifted
    '{32'h7F20_0000, 32'h6B00_0000, USE_RM | USE_RN | USE_RD},   // subs shifted
    '{32'h7FC0_0000, 32'h2880_0000, USE_RT2 | USE_RN | USE_RD},  // stp
    '{32'hBFE0_0000, 32'hB800_0000, USE_RN | USE_RD},            // stur/str
    '{32'hBFE0_0C00, 32'hB820_0800, USE_RN | USE_RD},            // str reg
    '{32'hBFE0_0C00, 32'hB800_0000, USE_RN | USE_RD},            // stur
    '{32'h7F80_03E0, 32'h3200_03E0, USE_RD},                     // mov bitmask
    '{32'h7FE0_FFE0, 32'h2A00_03E0, USE_RM | USE_RD},            // mov reg
    '{32'h7FFF_FC00, 32'h1100_0000, USE_RM | USE_RD},            // mov sp
    '{32'h7F80_0000, 32'h1280_0000, USE_RD},                     // movn
    '{32'h7F80_0000, 32'h5280_0000, USE_RD},                     // movz
    '{32'h7F80_0000, 32'h7280_0000, USE_RD}                      // movk
  };

  localparam int unsigned NUM_PICKS = 8;

  localparam logic [REG_W-1:0] PICK_ORDER [NUM_PICKS] = '{
    5'd16, 5'd17, 5'd15, 5'd14, 5'd13, 5'd12, 5'd11, 5'd10
  };

  typedef struct packed {
    logic [REG_W-1:0] branch_register;
    logic [REG_W-1:0] scratch_register;
    logic             status;
  } pick_result_t;

endpackage

// File: hdl/a64frf_decode.sv
// ----------------------------------------------------------------------------
// a64frf_decode: instruction word to register marks
// Match the word against every rule at once and mark the named fields.
// ----------------------------------------------------------------------------
module a64frf_decode (
  input  logic [a64frf_pkg::WORD_W-1:0]   word,
  output logic [a64frf_pkg::NUM_REGS-1:0] marks
);

  logic [3:0] uses;

  always_comb begin
    uses = '0;
    for (int i = 0; i < a64frf_pkg::NUM_RULES; i++) begin
      if ((word & a64frf_pkg::RULES[i].mask) == a64frf_pkg::RULES[i].pattern) begin
        uses = uses | a64frf_pkg::RULES[i].uses;
      end
    end
  end

  // Rd [4:0], Rn [9:5], Rt2 [14:10], Rm [20:16]
  always_comb begin
    marks = '0;
    if ((uses & a64frf_pkg::USE_RD) != '0) begin
      marks = marks | (32'd1 << word[4:0]);
    end
    if ((uses & a64frf_pkg::USE_RN) != '0) begin
      marks = marks | (32'd1 << word[9:5]);
    end
    if ((uses & a64frf_pkg::USE_RT2) != '0) begin
      marks = marks | (32'd1 << word[14:10]);
    end
    if ((uses & a64frf_pkg::USE_RM) != '0) begin
      marks = marks | (32'd1 << word[20:16]);
    end
  end

endmodule

// File: hdl/a64frf_pick.sv
// ----------------------------------------------------------------------------
// a64frf_pick: branch and scratch register selection
// Take the first free register in pick order twice, the second time with
// the branch register marked.
// ----------------------------------------------------------------------------
module a64frf_pick (
  input  logic [a64frf_pkg::NUM_REGS-1:0] map,
  output a64frf_pkg::pick_result_t        result
);

  logic [a64frf_pkg::REG_W-1:0]    branch;
  logic [a64frf_pkg::REG_W-1:0]    scratch;
  logic [a64frf_pkg::NUM_REGS-1:0] map2;

  function automatic logic [a64frf_pkg::REG_W-1:0] first_free(
    input logic [a64frf_pkg::NUM_REGS-1:0] m
  );
    logic [a64frf_pkg::REG_W-1:0] sel;
    sel = a64frf_pkg::NO_REG;
    // Walk backwards so the earliest free entry wins
    for (int i = a64frf_pkg::NUM_PICKS - 1; i >= 0; i--) begin
      if (!m[a64frf_pkg::PICK_ORDER[i]]) begin
        sel = a64frf_pkg::PICK_ORDER[i];
      end
    end
    return sel;
  endfunction

  always_comb begin
    branch = first_free(map);
    map2   = map;
    if (branch != a64frf_pkg::NO_REG) begin
      map2 = map | (32'd1 << branch);
    end
    scratch = first_free(map2);
    result.branch_register  = branch;
    result.scratch_register = scratch;
    result.status = (branch != a64frf_pkg::NO_REG && scratch != a64frf_pkg::NO_REG)
                    ? a64frf_pkg::STATUS_OK : a64frf_pkg::STATUS_FAIL;
  end

endmodule

// File: hdl/a64_free_register_finder.sv
// ----------------------------------------------------------------------------
// a64_free_register_finder: AArch64 free register finder
// Scans a run of instruction words and offers two unused scratch registers.
// ----------------------------------------------------------------------------
// The block takes one 32-bit AArch64 instruction word per beat and marks
// every register that a recognized add, sub, and, adr/adrp, stp, str/stur,
// mov or movz/movk/movn form names. The beat flagged last_word closes the
// run: one result beat follows with the first free register in the order
// x16, x17, x15, x14, x13, x12, x11, x10 as branch register, the next one as
// scratch register, and status 0 when both exist (a missing one reads 0 and
// status is 1). Registers set in reserved_mask (reset x8, x9, x18) are never
// offered. Words are taken at one beat per cycle unless in_stall holds them;
// a result passes through the input register, then the result register.
// Input stalls only while a last word waits for a result register that is
// still full and stalled. Write the reserved mask only while no word is in
// flight; a write inside a run takes effect for that run's pick. The write
// port is always ready.
module a64_free_register_finder (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [a64frf_pkg::NUM_REGS-1:0]    cfg_data,
  // input beats
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [a64frf_pkg::WORD_W-1:0]      in_instruction_word,
  input  logic                               in_last_word,
  // result beats
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [a64frf_pkg::REG_W-1:0]       out_branch_register,
  output logic [a64frf_pkg::REG_W-1:0]       out_scratch_register,
  output logic                               out_status
);

  // configuration register
  logic [a64frf_pkg::NUM_REGS-1:0] reserved_mask_r;

  // input register
  logic                            s1_valid_r;
  logic [a64frf_pkg::WORD_W-1:0]   s1_word_r;
  logic                            s1_last_r;

  // run state
  logic [a64frf_pkg::NUM_REGS-1:0] used_map_r;
  logic [a64frf_pkg::NUM_REGS-1:0] used_map_nxt;

  // result register
  logic                            out_valid_r;
  a64frf_pkg::pick_result_t        out_result_r;

  logic [a64frf_pkg::NUM_REGS-1:0] marks;
  logic [a64frf_pkg::NUM_REGS-1:0] pick_map;
  a64frf_pkg::pick_result_t        pick_result;
  logic                            s1_adv;
  logic                            in_accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_mask_r <= a64frf_pkg::RESERVED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      reserved_mask_r <= cfg_data;
    end
  end

  // A plain word always drains; a last word needs room in the result register
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_word_r <= in_instruction_word;
      s1_last_r <= in_last_word;
    end
  end

  a64frf_decode u_decode (
    .word  (s1_word_r),
    .marks (marks)
  );

  // The last word's own marks count toward the pick
  assign pick_map = used_map_r | marks | reserved_mask_r;

  a64frf_pick u_pick (
    .map    (pick_map),
    .result (pick_result)
  );

  // Accumulate marks; restart from the reserved mask after a last word
  always_comb begin
    used_map_nxt = used_map_r;
    if (s1_adv) begin
      if (s1_last_r) begin
        used_map_nxt = reserved_mask_r;
      end else begin
        used_map_nxt = used_map_r | marks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_map_r <= a64frf_pkg::RESERVED_RESET;
    end else begin
      used_map_r <= used_map_nxt;
    end
  end

  // Load on a last word, drop once taken, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_result_r <= pick_result;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_branch_register  = out_result_r.branch_register;
  assign out_scratch_register = out_result_r.scratch_register;
  assign out_status           = out_result_r.status;

  // The input side only waits behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked last word");

  // A closed run restarts from the reserved mask
  a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (used_map_r == $past(reserved_mask_r)))
    else $error("used map not restored after last word");

  // Within a run the used map only gains marks
  a_map_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_last_r) |=> ((used_map_r & $past(used_map_r)) == $past(used_map_r)))
    else $error("used map lost a mark inside a run");

  // A success names two distinct registers
  a_ok_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status == a64frf_pkg::STATUS_OK) |->
      (out_branch_register != a64frf_pkg::NO_REG &&
       out_scratch_register != a64frf_pkg::NO_REG &&
       out_branch_register != out_scratch_register))
    else $error("success status with missing or equal registers");

endmodule

// File: tb/tb_a64_free_register_finder.sv
// ----------------------------------------------------------------------------
// tb_a64_free_register_finder: self-checking bench for the free register finder
// Streams runs of AArch64 instruction words through the block, predicts the
// branch/scratch pick of every run and compares each result beat in order.
// ----------------------------------------------------------------------------
module tb_a64_free_register_finder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD     = 12;
  localparam int          RESET_CYCLES   = 9;
  localparam int          SETTLE_CYCLES  = 6;      // two-stage pipe plus margin
  localparam int          CYCLE_LIMIT    = 400000;
  localparam int          NUM_PHASES     = 8;
  localparam int          PHASE_ITEMS    = 141;
  localparam logic [31:0] RESET_RESERVED = 32'h0004_0300;

  // Register fields an instruction form names
  localparam logic [3:0] FLD_RD  = 4'b0001;
  localparam logic [3:0] FLD_RN  = 4'b0010;
  localparam logic [3:0] FLD_RM  = 4'b0100;
  localparam logic [3:0] FLD_RT2 = 4'b1000;

  // Recognized instruction forms, one decode entry each
  typedef enum int {
    OP_ADD_EXT, OP_ADDS_EXT, OP_ADD_IMM, OP_ADDS_IMM, OP_ADD_SHIFT, OP_ADDS_SHIFT,
    OP_ADR, OP_ADRP, OP_AND_IMM, OP_ANDS_IMM, OP_AND_SHIFT, OP_ANDS_SHIFT,
    OP_SUB_EXT, OP_SUBS_EXT, OP_SUB_IMM, OP_SUBS_IMM, OP_SUB_SHIFT, OP_SUBS_SHIFT,
    OP_STP, OP_STR_IMM, OP_STR_REG, OP_STUR, OP_MOV_BITMASK, OP_MOV_REG, OP_MOV_SP,
    OP_MOVN, OP_MOVZ, OP_MOVK, NUM_OPS
  } a64_op_e;

  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] value;
    logic [3:0]  regs;
  } decode_entry_t;

  localparam decode_entry_t DECODE [NUM_OPS] = '{
    '{32'h7FE0_0000, 32'h0B20_0000, FLD_RM | FLD_RN | FLD_RD},
    '{32'h7FE0_0000, 32'h2B20_0000, FLD_RM | FLD_RN | FLD_RD},
    '{32'h7F80_0000, 32'h1100_0000, FLD_RN | FLD_RD},
    '{32'h7F80_0000, 32'h3100_0000, FLD_RN | FLD_RD},
    '{32'h7F20_0000, 32'h0B00_0000, FLD_RM | FLD_RN | FLD_RD},
    '{32'h7F20_0000, 32'h2B00_0000, FLD_RM | FLD_RN | FLD_RD},
    '{32'h9F00_0000, 32'h1000_0000, FLD_RD},
    '{32'h9F00_0000, 32'h9000_0000, FLD_RD},
    '{32'h7F80_0000, 32'h1200_0000, FLD_RN | FLD_RD},
    '{32'h7F80_0000, 32'h7200_0000, FLD_RN | FLD_RD},
    '{32'h7F20_0000, 32'h0A00_0000, FLD_RM | FLD_RN | FLD_RD},
    '{32'h7F20_0000, 32'h6A00_0000, FLD_RM | FLD_RN | FLD_RD},
    '{32'h7FE0_0000, 32'h4B20_0000, FLD_RM | FLD_RN | FLD_RD},
    '{32'h7FE0_0000, 32'h6B20_0000, FLD_RM | FLD_RN | FLD_RD},
    '{32'h7F80_0000, 32'h5100_0000, FLD_RN | FLD_RD},
    '{32'h7F80_0000, 32'h7100_0000, FLD_RN | FLD_RD},
    '{32'h7F20_0000, 32'h4B00_0000, FLD_RM | FLD_RN | FLD_RD},
    '{32'h7F20_0000, 32'h6B00_0000, FLD_RM | FLD_RN | FLD_RD},
    '{32'h7FC0_0000, 32'h2880_0000, FLD_RT2 | FLD_RN | FLD_RD},
    '{32'hBFE0_0000, 32'hB800_0000, FLD_RN | FLD_RD},
    '{32'hBFE0_0C00, 32'hB820_0800, FLD_RN | FLD_RD},
    '{32'hBFE0_0C00, 32'hB800_0000, FLD_RN | FLD_RD},
    '{32'h7F80_03E0, 32'h3200_03E0, FLD_RD},
    '{32'h7FE0_FFE0, 32'h2A00_03E0, FLD_RM | FLD_RD},
    '{32'h7FFF_FC00, 32'h1100_0000, FLD_RM | FLD_RD},
    '{32'h7F80_0000, 32'h1280_0000, FLD_RD},
    '{32'h7F80_0000, 32'h5280_0000, FLD_RD},
    '{32'h7F80_0000, 32'h7280_0000, FLD_RD}
  };

  // Candidate registers, most preferred first
  localparam logic [4:0] SCAN_ORDER [8] = '{
    5'd16, 5'd17, 5'd15, 5'd14, 5'd13, 5'd12, 5'd11, 5'd10
  };

  // Tracks the register usage of the open run and queues the pick of each
  // closed run until its result beat shows up.
  class register_pick_board;
    logic [31:0]              reserved_mask;
    logic [31:0]              used_map;
    a64frf_pkg::pick_result_t expected_picks[$];
    int                       errors;

    function new();
      reserved_mask = RESET_RESERVED;
      used_map      = RESET_RESERVED;
      errors        = 0;
    endfunction

    function void set_reserved(logic [31:0] mask);
      reserved_mask = mask;
    endfunction

    function int pending();
      return expected_picks.size();
    endfunction

    function logic [31:0] word_marks(logic [31:0] word);
      logic [31:0] marks;
      marks = '0;
      for (int i = 0; i < NUM_OPS; i++) begin
        if ((word & DECODE[i].mask) == DECODE[i].value) begin
          if (DECODE[i].regs & FLD_RD)  marks[word[4:0]]   = 1'b1;
          if (DECODE[i].regs & FLD_RN)  marks[word[9:5]]   = 1'b1;
          if (DECODE[i].regs & FLD_RT2) marks[word[14:10]] = 1'b1;
          if (DECODE[i].regs & FLD_RM)  marks[word[20:16]] = 1'b1;
        end
      end
      return marks;
    endfunction

    function logic [4:0] first_free(logic [31:0] map);
      for (int i = 0; i < 8; i++)
        if (!map[SCAN_ORDER[i]]) return SCAN_ORDER[i];
      return a64frf_pkg::NO_REG;
    endfunction

    function void note_word(logic [31:0] word, logic is_last);
      logic [31:0]              map;
      a64frf_pkg::pick_result_t pick;
      used_map |= word_marks(word);
      if (!is_last) return;
      map = used_map | reserved_mask;
      pick.branch_register = first_free(map);
      if (pick.branch_register != a64frf_pkg::NO_REG) map[pick.branch_register] = 1'b1;
      pick.scratch_register = first_free(map);
      pick.status = (pick.branch_register != a64frf_pkg::NO_REG &&
                     pick.scratch_register != a64frf_pkg::NO_REG) ?
                    a64frf_pkg::STATUS_OK : a64frf_pkg::STATUS_FAIL;
      expected_picks.push_back(pick);
      used_map = reserved_mask;
    endfunction

    function void check_pick(logic [4:0] branch, logic [4:0] scratch, logic status);
      a64frf_pkg::pick_result_t want;
      if (expected_picks.size() == 0) begin
        $display("%0t: unexpected result beat: branch %0d scratch %0d status %0b",
                 $time, branch, scratch, status);
        errors++;
        return;
      end
      want = expected_picks.pop_front();
      if (branch !== want.branch_register) begin
        $display("%0t: branch_register expected %0d actual %0d",
                 $time, want.branch_register, branch);
        errors++;
      end
      if (scratch !== want.scratch_register) begin
        $display("%0t: scratch_register expected %0d actual %0d",
                 $time, want.scratch_register, scratch);
        errors++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0b actual %0b", $time, want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_instruction_word = '0;
  logic        in_last_word = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_branch_register;
  logic [4:0]  out_scratch_register;
  logic        out_status;

  register_pick_board picks;
  int burst_left = 0;

  a64_free_register_finder uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_instruction_word  (in_instruction_word),
    .in_last_word         (in_last_word),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_branch_register  (out_branch_register),
    .out_scratch_register (out_scratch_register),
    .out_status           (out_status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Give up if the run hangs anywhere
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: switch between random stall patterns and hold off for
  // a long stretch now and then, so the result register fills up and the
  // next last word backs up into the input.
  int rx_cycle = 0;
  int rx_mode = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left == 0 && rx_cycle % 900 == 600) hold_left = 100;
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (rx_cycle % 2 == 1);
      endcase
    end
  end

  // Check every result beat taken at this edge; the sampled values are
  // the ones from before the edge since everything updates nonblocking.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      picks.check_pick(out_branch_register, out_scratch_register, out_status);
  end

  // Offer one word and hold it until the block takes the beat. Then either
  // keep valid up for the next beat of the burst or drop it for a gap.
  task automatic send_word(input logic [31:0] word, input logic is_last);
    in_valid            <= 1'b1;
    in_instruction_word <= word;
    in_last_word        <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    picks.note_word(word, is_last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
                                                 $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Write the reserved mask once the block is idle: drain every pending
  // pick, then let the pipe settle in case a word without result is in it.
  task automatic write_reserved(input logic [31:0] mask);
    in_valid <= 1'b0;
    while (picks.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mask;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    picks.set_reserved(mask);
  endtask

  // Encode a form with the given register fields; everything the form
  // leaves open stays random.
  function automatic logic [31:0] build_word(a64_op_e op, logic [4:0] rd, logic [4:0] rn,
                                             logic [4:0] rt2, logic [4:0] rm);
    logic [31:0] w;
    w = $urandom;
    w[4:0]   = rd;
    w[9:5]   = rn;
    w[14:10] = rt2;
    w[20:16] = rm;
    return (w & ~DECODE[op].mask) | DECODE[op].value;
  endfunction

  // Lean toward the candidate registers so runs often exhaust them
  function automatic logic [4:0] biased_reg();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 5'($urandom_range(10, 17));
    if (roll < 65) return 5'd31;
    if (roll < 72) return (roll % 2 == 0) ? 5'd18 : 5'($urandom_range(8, 9));
    return 5'($urandom_range(0, 31));
  endfunction

  // Mostly recognized forms, some raw noise
  function automatic logic [31:0] random_word();
    if ($urandom_range(0, 99) < 15) return $urandom;
    return build_word(a64_op_e'($urandom_range(0, NUM_OPS - 1)),
                      biased_reg(), biased_reg(), biased_reg(), biased_reg());
  endfunction

  function automatic logic [31:0] phase_mask(int phase);
    case (phase)
      1:       return 32'h0000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom;
      4:       return ~(32'h1 << $urandom_range(10, 17));   // one candidate left
      5:       return $urandom & 32'h0003_FC00;
      6:       return $urandom & 32'hFFFF_0000;
      default: return RESET_RESERVED;
    endcase
  endfunction

  initial begin
    int sent;
    int run_len;
    picks = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Extremes of the word as single-word runs
    send_word(32'h0000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1);

    // Add, sub and and forms, field values 0 and 31, adds immediate at the end
    send_word(build_word(OP_ADD_EXT, 5'd0, 5'd1, 5'd0, 5'd2), 1'b0);
    send_word(build_word(OP_SUB_SHIFT, 5'd31, 5'd31, 5'd0, 5'd31), 1'b0);
    send_word(build_word(OP_AND_IMM, 5'd20, 5'd21, 5'd0, 5'd0), 1'b0);
    send_word(build_word(OP_ANDS_SHIFT, 5'd22, 5'd23, 5'd0, 5'd24), 1'b0);
    send_word(build_word(OP_ADDS_IMM, 5'd16, 5'd17, 5'd0, 5'd0), 1'b1);

    // Address, store and move forms; only x10 stays free, so no scratch
    send_word(build_word(OP_ADR, 5'd16, 5'd0, 5'd0, 5'd0), 1'b0);
    send_word(build_word(OP_ADRP, 5'd17, 5'd0, 5'd0, 5'd0), 1'b0);
    send_word(build_word(OP_STP, 5'd15, 5'd14, 5'd31, 5'd0), 1'b0);
    send_word(build_word(OP_STR_IMM, 5'd13, 5'd0, 5'd0, 5'd0), 1'b0);
    send_word(build_word(OP_STR_REG, 5'd12, 5'd31, 5'd0, 5'd0), 1'b0);
    send_word(build_word(OP_STUR, 5'd11, 5'd1, 5'd0, 5'd0), 1'b0);
    send_word(build_word(OP_MOV_BITMASK, 5'd2, 5'd0, 5'd0, 5'd0), 1'b0);
    send_word(build_word(OP_MOV_REG, 5'd3, 5'd0, 5'd0, 5'd4), 1'b0);
    send_word(build_word(OP_MOVN, 5'd5, 5'd0, 5'd0, 5'd0), 1'b0);
    send_word(build_word(OP_MOVZ, 5'd6, 5'd0, 5'd0, 5'd0), 1'b0);
    send_word(build_word(OP_MOVK, 5'd7, 5'd0, 5'd0, 5'd0), 1'b1);

    // Mov to/from sp overlaps add immediate: both sets of fields count.
    // The run then uses up every candidate, so both picks come back empty.
    send_word(build_word(OP_MOV_SP, 5'd10, 5'd0, 5'd0, 5'd0), 1'b0);
    send_word(build_word(OP_STP, 5'd16, 5'd17, 5'd15, 5'd0), 1'b0);
    send_word(build_word(OP_ADD_SHIFT, 5'd14, 5'd13, 5'd0, 5'd12), 1'b0);
    send_word(build_word(OP_AND_SHIFT, 5'd11, 5'd31, 5'd0, 5'd31), 1'b1);

    // Reserve a register in the middle of a run: it applies to this pick
    send_word(build_word(OP_ADD_IMM, 5'd16, 5'd16, 5'd0, 5'd0), 1'b0);
    write_reserved(32'h1 << 17);
    send_word(32'h0000_0000, 1'b1);

    // Random runs, one reserved mask per phase
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_reserved(phase_mask(phase));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        run_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 10) : $urandom_range(11, 40);
        for (int k = 1; k <= run_len; k++)
          send_word(random_word(), k == run_len);
        sent += run_len;
      end
    end

    // Drain the last picks and let the pipe go quiet
    in_valid <= 1'b0;
    while (picks.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (picks.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
hdl/a64frf_pkg.sv
hdl/a64frf_decode.sv
hdl/a64frf_pick.sv
hdl/a64_free_register_finder.sv
tb/tb_a64_free_register_finder.sv
